// ===== rtl/cbm_pkg.sv =====
// Shared types and constants of the cartridge bank mapper.
// Holds the transaction structs, access kind codes and mapper constants.
// Has no dependencies.
package cbm_pkg;

   localparam int NumSlots = 6;
   localparam int SlotBits = 3;
   localparam int PageBits = 8;
   localparam int AddrBits = 16;
   localparam int DataBits = 8;
   localparam int OfsBits = 13;
   localparam int RomBits = 21;

   localparam logic [AddrBits-1:0] BankRegAddr = 16'hBFFC;
   localparam logic [AddrBits-1:0] RamBase = 16'hC000;
   localparam logic [DataBits-1:0] MaskLow = 8'h3E;
   localparam logic [DataBits-1:0] MaskFull = 8'h3F;
   localparam logic [5:0] FixedLower = 6'h20;
   localparam logic [PageBits-1:0] FixedPage = 8'h7F;
   localparam logic [PageBits-1:0] MaskReset = 8'h7F;

   localparam logic [1:0] ModeSplit = 2'd0;
   localparam logic [1:0] ModeSame = 2'd1;
   localparam logic [1:0] ModeFixed = 2'd2;
   localparam logic [1:0] ModeMirror = 2'd3;

   typedef enum logic [2:0] {
      KIND_ROM_READ  = 3'd0,
      KIND_RAM_READ  = 3'd1,
      KIND_RAM_WRITE = 3'd2,
      KIND_BANK_REG  = 3'd3,
      KIND_IGNORED   = 3'd4
   } access_kind_type;

   typedef logic [NumSlots-1:0][PageBits-1:0] page_array_type;

   typedef struct packed {
      logic                op;
      logic [AddrBits-1:0] bus_address;
      logic [DataBits-1:0] write_data;
   } req_type;

   typedef struct packed {
      access_kind_type     access_kind;
      logic [RomBits-1:0]  rom_address;
      logic [OfsBits-1:0]  ram_offset;
      logic [DataBits-1:0] ram_write_data;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic [DataBits-1:0] value;
   } bank_write_type;

endpackage

// ===== rtl/cbm_translate.sv =====
// Combinational decode and address translation of one bus transaction.
// Depends on cbm_pkg for the transaction structs and kind codes.
module cbm_translate (
   input  cbm_pkg::req_type        req,
   input  cbm_pkg::page_array_type pages,
   output cbm_pkg::rsp_type        rsp,
   output cbm_pkg::bank_write_type bank_write
);
   import cbm_pkg::*;

   logic [SlotBits-1:0] slot;
   logic [PageBits-1:0] page;
   logic                is_ram;

   assign slot = req.bus_address[AddrBits-1 -: SlotBits];
   assign page = (slot < SlotBits'(NumSlots)) ? pages[slot] : '0;
   assign is_ram = req.bus_address >= RamBase;

   always_comb begin
      rsp = '0;
      rsp.access_kind = KIND_IGNORED;
      bank_write.load = 1'b0;
      bank_write.value = req.write_data;
      if (!req.op) begin
         if (!is_ram) begin
            rsp.access_kind = KIND_ROM_READ;
            rsp.rom_address = {page, req.bus_address[OfsBits-1:0]};
         end else begin
            rsp.access_kind = KIND_RAM_READ;
            rsp.ram_offset = req.bus_address[OfsBits-1:0];
         end
      end else begin
         if (req.bus_address == BankRegAddr) begin
            rsp.access_kind = KIND_BANK_REG;
            bank_write.load = 1'b1;
         end else if (is_ram) begin
            rsp.access_kind = KIND_RAM_WRITE;
            rsp.ram_offset = req.bus_address[OfsBits-1:0];
            rsp.ram_write_data = req.write_data;
         end
      end
   end

endmodule

// ===== rtl/cbm_page_regs.sv =====
// Slot page registers and ROM bank mask of the cartridge bank mapper.
// Depends on cbm_pkg for the page array type and mode codes.
module cbm_page_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [7:0]              csr_value,
   input  logic                    update,
   input  cbm_pkg::bank_write_type bank_write,
   output cbm_pkg::page_array_type pages
);
   import cbm_pkg::*;

   page_array_type      pages_ff;
   page_array_type      pages_in;
   logic [PageBits-1:0] mask_ff;
   logic [PageBits-1:0] mask_in;
   logic [1:0]          mode;
   logic [5:0]          lower;
   logic [5:0]          upper;
   logic [PageBits-1:0] page_lo;
   logic [PageBits-1:0] page_up;

   assign mode = bank_write.value[7:6];

   always_comb begin
      unique case (mode)
         ModeSplit: begin
            lower = bank_write.value[5:0] & MaskLow[5:0];
            upper = lower | 6'd1;
         end
         ModeSame: begin
            lower = bank_write.value[5:0] & MaskFull[5:0];
            upper = lower;
         end
         default: begin
            lower = FixedLower;
            upper = bank_write.value[5:0] & MaskFull[5:0];
         end
      endcase
      page_lo = {1'b0, lower, 1'b0} & mask_ff;
      page_up = {1'b0, upper, 1'b0} & mask_ff;

      pages_in = pages_ff;
      mask_in = csr_write ? csr_value : mask_ff;
      if (update && bank_write.load) begin
         pages_in[0] = page_lo;
         pages_in[1] = page_lo + PageBits'(1);
         pages_in[2] = page_up;
         pages_in[3] = page_up + PageBits'(1);
         if (mode == ModeMirror) begin
            pages_in[4] = page_up + PageBits'(1);
            pages_in[5] = page_up;
         end else begin
            pages_in[4] = FixedPage & mask_ff;
            pages_in[5] = FixedPage & mask_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSlots; i++) begin
            pages_ff[i] <= PageBits'(i);
         end
         mask_ff <= MaskReset;
      end else begin
         pages_ff <= pages_in;
         mask_ff <= mask_in;
      end
   end

   assign pages = pages_ff;

endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: translates CPU bus transactions into ROM and RAM accesses.
// A transaction passes an input register, then the decode into the result register.
// One transaction is taken every cycle unless the response side stalls; the
// bank register write updates the pages as it passes the decode, so later reads see it.
// Depends on cbm_pkg, cbm_translate and cbm_page_regs.
module cartridge_bank_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // bus_address[15:0], write_data[23:16]
   input  logic [0:0]  req_tuser,  // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // rom_address[20:0], ram_offset[33:21],
                                   // ram_write_data[41:34], zero[47:42]
   output logic [2:0]  rsp_tuser,  // access_kind[2:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import cbm_pkg::*;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_type        s1_req_ff;
   req_type        s1_req_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           out_ready;
   logic           advance;
   page_array_type pages;
   rsp_type        rsp_next;
   bank_write_type bank_write;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign advance = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign csr_ready = 1'b1;

   cbm_translate u_translate (
      .req        (s1_req_ff),
      .pages      (pages),
      .rsp        (rsp_next),
      .bank_write (bank_write)
   );

   cbm_page_regs u_page_regs (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .update     (advance),
      .bank_write (bank_write),
      .pages      (pages)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in = s1_req_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_req_in.op = req_tuser[0];
         s1_req_in.bus_address = req_tdata[15:0];
         s1_req_in.write_data = req_tdata[23:16];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.access_kind;
   assign rsp_tdata = {6'd0, rsp_ff.ram_write_data, rsp_ff.ram_offset, rsp_ff.rom_address};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the cartridge bank mapper: directed and random bus accesses
// with and without random stalls on both sides, checked against a slot page predictor.
// Depends on cbm_pkg and cartridge_bank_mapper.
module tb_top;
   import cbm_pkg::*;

   localparam logic OpRead = 1'b0;
   localparam logic OpWrite = 1'b1;
   localparam int StallLimit = 10000;
   localparam int PhaseItems = 285;

   class mapper_scoreboard;
      logic [PageBits-1:0] slot_page [NumSlots];
      logic [DataBits-1:0] rom_mask;
      rsp_type expected_rsp [$];
      int failures;
      int kind_count [5];

      function new();
         for (int i = 0; i < NumSlots; i++) slot_page[i] = PageBits'(i);
         rom_mask = MaskReset;
         failures = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void load_pages(logic [DataBits-1:0] value);
         logic [1:0] mode;
         logic [DataBits-1:0] lower;
         logic [DataBits-1:0] upper;
         logic [PageBits-1:0] first;
         logic [PageBits-1:0] second;
         mode = value[7:6];
         if (mode == ModeSplit) begin
            lower = value & MaskLow;
            upper = lower | 8'd1;
         end else if (mode == ModeSame) begin
            lower = value & MaskFull;
            upper = lower;
         end else begin
            lower = DataBits'(FixedLower);
            upper = value & MaskFull;
         end
         first = {lower[6:0], 1'b0} & rom_mask;
         second = {upper[6:0], 1'b0} & rom_mask;
         slot_page[0] = first;
         slot_page[1] = first + 8'd1;
         slot_page[2] = second;
         slot_page[3] = second + 8'd1;
         if (mode == ModeMirror) begin
            slot_page[4] = second + 8'd1;
            slot_page[5] = second;
         end else begin
            slot_page[4] = FixedPage & rom_mask;
            slot_page[5] = FixedPage & rom_mask;
         end
      endfunction

      function void note_request(logic op, logic [AddrBits-1:0] addr,
                                 logic [DataBits-1:0] data);
         rsp_type want;
         want = '0;
         if (op == OpRead) begin
            if (addr < RamBase) begin
               want.access_kind = KIND_ROM_READ;
               want.rom_address = {slot_page[addr[15:13]], 13'd0} + RomBits'(addr[12:0]);
            end else begin
               want.access_kind = KIND_RAM_READ;
               want.ram_offset = addr[12:0];
            end
         end else if (addr == BankRegAddr) begin
            want.access_kind = KIND_BANK_REG;
            load_pages(data);
         end else if (addr >= RamBase) begin
            want.access_kind = KIND_RAM_WRITE;
            want.ram_offset = addr[12:0];
            want.ram_write_data = data;
         end else begin
            want.access_kind = KIND_IGNORED;
         end
         expected_rsp.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("response with none expected: access_kind %0d", got.access_kind);
            failures++;
            return;
         end
         want = expected_rsp.pop_front();
         kind_count[want.access_kind]++;
         if (got.access_kind !== want.access_kind) begin
            $error("access_kind: expected %0d, actual %0d", want.access_kind, got.access_kind);
            failures++;
         end
         if (got.rom_address !== want.rom_address) begin
            $error("rom_address: expected %0h, actual %0h", want.rom_address, got.rom_address);
            failures++;
         end
         if (got.ram_offset !== want.ram_offset) begin
            $error("ram_offset: expected %0h, actual %0h", want.ram_offset, got.ram_offset);
            failures++;
         end
         if (got.ram_write_data !== want.ram_write_data) begin
            $error("ram_write_data: expected %0h, actual %0h",
                   want.ram_write_data, got.ram_write_data);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   mapper_scoreboard sb = new();
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_cycles = 0;
   int mask_writes = 0;

   cartridge_bank_mapper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_type got;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.access_kind = access_kind_type'(rsp_tuser);
         got.rom_address = rsp_tdata[20:0];
         got.ram_offset = rsp_tdata[33:21];
         got.ram_write_data = rsp_tdata[41:34];
         sb.check_response(got);
      end
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {data, addr};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, addr, data);
   endtask

   task automatic random_access();
      int pick;
      logic [15:0] addr;
      pick = $urandom_range(99);
      if (pick < 55) begin
         addr = ($urandom_range(3) != 0) ? 16'($urandom_range(16'hBFFF))
                                         : 16'($urandom_range(16'hFFFF));
         send_access(OpRead, addr, 8'($urandom_range(255)));
      end else if (pick < 70) begin
         send_access(OpWrite, BankRegAddr, 8'($urandom_range(255)));
      end else if (pick < 85) begin
         send_access(OpWrite, 16'($urandom_range(16'hFFFF, 16'hC000)), 8'($urandom_range(255)));
      end else begin
         send_access(OpWrite, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_mask(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.rom_mask = value;
      mask_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] mask_plan [6];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      mask_plan = '{8'hFF, 8'h00, 8'h3F, 8'h07, 8'h00, 8'h7F};
      mask_plan[4] = 8'($urandom_range(255));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 37;
      rsp_idle_pct = 48;
      send_access(OpRead, 16'h0000, 8'h00);
      send_access(OpRead, 16'hBFFF, 8'h00);
      send_access(OpRead, 16'hC000, 8'hFF);
      send_access(OpRead, 16'hFFFF, 8'h00);
      send_access(OpWrite, 16'hC000, 8'h00);
      send_access(OpWrite, 16'hFFFF, 8'hFF);
      send_access(OpWrite, 16'h0000, 8'hFF);
      send_access(OpWrite, 16'hBFFB, 8'h12);
      send_access(OpWrite, 16'hBFFD, 8'h34);
      send_access(OpWrite, BankRegAddr, 8'h3F);
      send_access(OpRead, 16'h1ABC, 8'h00);
      send_access(OpRead, BankRegAddr, 8'h00);
      send_access(OpWrite, BankRegAddr, 8'h7F);
      send_access(OpRead, 16'h2000, 8'h00);
      send_access(OpRead, 16'h9FFF, 8'h00);
      send_access(OpWrite, BankRegAddr, 8'h80);
      send_access(OpRead, 16'h0001, 8'h00);
      send_access(OpRead, 16'hA000, 8'h00);
      send_access(OpWrite, BankRegAddr, 8'hFF);
      send_access(OpRead, 16'h6000, 8'h00);
      send_access(OpRead, 16'h8000, 8'h00);
      send_access(OpRead, 16'hA123, 8'h00);
      send_access(OpWrite, BankRegAddr, 8'h00);
      send_access(OpRead, 16'h7FFF, 8'h00);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 37;
               rsp_idle_pct = 48;
            end
            1: begin
               req_idle_pct = 48;
               rsp_idle_pct = 37;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         write_mask(mask_plan[phase]);
         repeat (PhaseItems) random_access();
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d ROM reads, %0d RAM reads, %0d RAM writes, %0d bank writes,",
               sb.kind_count[KIND_ROM_READ], sb.kind_count[KIND_RAM_READ],
               sb.kind_count[KIND_RAM_WRITE], sb.kind_count[KIND_BANK_REG]);
      $display("%0d ignored writes and %0d bank mask settings.",
               sb.kind_count[KIND_IGNORED], mask_writes);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
